### rtl/bpa_pkg.sv
package bpa_pkg;

	localparam int PAGE_BITS = 12;
	localparam int TOP_ORDER = 10;
	localparam int MAX_PAGES = 1024;

	localparam int NLISTS    = TOP_ORDER + 1;
	localparam int IDX_W     = $clog2(MAX_PAGES + 1);
	localparam int PG_W      = $clog2(MAX_PAGES);
	localparam int ORD_W     = 4;
	localparam int CUR_W     = $clog2(TOP_ORDER + 2);
	localparam int LW        = $clog2(NLISTS);
	localparam int STEPS_W   = $clog2(MAX_PAGES + 2);
	localparam int WORD_W    = IDX_W + ORD_W + 1;

	// undo log: one entry for the initial mark plus three per merge level
	localparam int LOG_DEPTH = 3 * TOP_ORDER + 1;
	localparam int LOG_AW    = $clog2(LOG_DEPTH);
	localparam int LOG_CW    = $clog2(LOG_DEPTH + 1);
	localparam int LOG_W     = PG_W + WORD_W;

	localparam logic [IDX_W-1:0] NIL   = IDX_W'(MAX_PAGES);
	localparam logic [32:0]      PMASK = 33'((64'd1 << PAGE_BITS) - 64'd1);

	localparam logic [2:0] K_ORD   = 3'd0;
	localparam logic [2:0] K_BYTES = 3'd1;
	localparam logic [2:0] K_PAGES = 3'd2;
	localparam logic [2:0] K_FREE  = 3'd3;
	localparam logic [2:0] K_ADD   = 3'd4;

	localparam logic [3:0] ST_OK    = 4'd0;
	localparam logic [3:0] ST_NULL  = 4'd1;
	localparam logic [3:0] ST_BIG   = 4'd2;
	localparam logic [3:0] ST_EMPTY = 4'd3;
	localparam logic [3:0] ST_ALIGN = 4'd4;
	localparam logic [3:0] ST_RANGE = 4'd5;
	localparam logic [3:0] ST_DFREE = 4'd6;
	localparam logic [3:0] ST_BLK   = 4'd7;
	localparam logic [3:0] ST_SMALL = 4'd8;
	localparam logic [3:0] ST_WRAP  = 4'd9;

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] S_IDLE  = 5'd0;
	localparam logic [STEP_W-1:0] S_DEC   = 5'd1;
	localparam logic [STEP_W-1:0] S_SIZE  = 5'd2;
	localparam logic [STEP_W-1:0] S_SCAN  = 5'd3;
	localparam logic [STEP_W-1:0] S_POP   = 5'd4;
	localparam logic [STEP_W-1:0] S_SPLIT = 5'd5;
	localparam logic [STEP_W-1:0] S_FRD   = 5'd6;
	localparam logic [STEP_W-1:0] S_FLOOP = 5'd7;
	localparam logic [STEP_W-1:0] S_FBUD  = 5'd8;
	localparam logic [STEP_W-1:0] S_UCHK  = 5'd9;
	localparam logic [STEP_W-1:0] S_UNXT  = 5'd10;
	localparam logic [STEP_W-1:0] S_UPW   = 5'd11;
	localparam logic [STEP_W-1:0] S_UBW   = 5'd12;
	localparam logic [STEP_W-1:0] S_MRQ   = 5'd13;
	localparam logic [STEP_W-1:0] S_MWR   = 5'd14;
	localparam logic [STEP_W-1:0] S_PUSHR = 5'd15;
	localparam logic [STEP_W-1:0] S_PUSHW = 5'd16;
	localparam logic [STEP_W-1:0] S_RST   = 5'd17;
	localparam logic [STEP_W-1:0] S_RRD   = 5'd18;
	localparam logic [STEP_W-1:0] S_RWR   = 5'd19;
	localparam logic [STEP_W-1:0] S_SWEEP = 5'd20;
	localparam logic [STEP_W-1:0] S_GORD  = 5'd21;
	localparam logic [STEP_W-1:0] S_DONE  = 5'd22;

	typedef struct packed {
		logic [IDX_W-1:0] nxt;
		logic [ORD_W-1:0] ord;
		logic             fr;
	} word_t;

	typedef struct packed {
		logic [PG_W-1:0] a;
		word_t           w;
	} log_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic              load;
	} cmd_t;

	typedef struct packed {
		logic dec_err;
		logic k_ord;
		logic k_size;
		logic k_free;
		logic k_add;
		logic size_over;
		logic size_fit;
		logic scan_over;
		logic scan_hit;
		logic split_more;
		logic fchk_err;
		logic floop_stop;
		logic fbud_stop;
		logic u_fail;
		logic u_hit;
		logic u_prev_nil;
		logic log_empty;
		logic sweep_last;
		logic g_end;
	} stat_t;

endpackage

### rtl/bpa_ram.sv
module bpa_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/bpa_ctrl.sv
module bpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bpa_pkg::stat_t stat,
	output bpa_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);
	import bpa_pkg::*;

	logic [STEP_W-1:0] state_q;
	logic [STEP_W-1:0] state_d;

	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_DONE);
	assign cmd.step = state_q;
	assign cmd.load = start && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_DEC;
			S_DEC: begin
				priority if (stat.dec_err) state_d = S_DONE;
				else if (stat.k_ord)       state_d = S_SCAN;
				else if (stat.k_size)      state_d = S_SIZE;
				else if (stat.k_free)      state_d = S_FRD;
				else if (stat.k_add)       state_d = S_SWEEP;
				else                       state_d = S_DONE;
			end
			S_SIZE: begin
				priority if (stat.size_over) state_d = S_DONE;
				else if (stat.size_fit)      state_d = S_SCAN;
			end
			S_SCAN: begin
				priority if (stat.scan_over) state_d = S_DONE;
				else if (stat.scan_hit)      state_d = S_POP;
			end
			S_POP:   state_d = S_SPLIT;
			S_SPLIT: if (!stat.split_more) state_d = S_DONE;
			S_FRD:   state_d = stat.fchk_err ? S_DONE : S_FLOOP;
			S_FLOOP: state_d = stat.floop_stop ? S_PUSHR : S_FBUD;
			S_FBUD:  state_d = stat.fbud_stop ? S_PUSHR : S_UCHK;
			S_UCHK: begin
				priority if (stat.u_fail)             state_d = S_RST;
				else if (stat.u_hit && stat.u_prev_nil) state_d = S_UBW;
				else if (stat.u_hit)                  state_d = S_UPW;
				else                                  state_d = S_UNXT;
			end
			S_UNXT:  state_d = S_UCHK;
			S_UPW:   state_d = S_UBW;
			S_UBW:   state_d = S_MRQ;
			S_MRQ:   state_d = S_MWR;
			S_MWR:   state_d = S_FLOOP;
			S_PUSHR: state_d = S_PUSHW;
			S_PUSHW: state_d = S_DONE;
			S_RST:   state_d = stat.log_empty ? S_DONE : S_RRD;
			S_RRD:   state_d = S_RWR;
			S_RWR:   state_d = stat.log_empty ? S_DONE : S_RRD;
			S_SWEEP: if (stat.sweep_last) state_d = S_GORD;
			S_GORD:  if (stat.g_end) state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### rtl/bpa_dpath.sv
module bpa_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  bpa_pkg::cmd_t  cmd,
	output bpa_pkg::stat_t stat,
	input  logic [2:0]     kind,
	input  logic [3:0]     order,
	input  logic [31:0]    request_size,
	input  logic [31:0]    address,
	output logic [31:0]    block_address,
	output logic [3:0]     status
);
	import bpa_pkg::*;

	// latched request
	logic [2:0]  kind_q;
	logic [3:0]  ordin_q;
	logic [31:0] req_q;
	logic [31:0] adr_q;

	// allocator state
	logic [31:0]      base_q;
	logic [IDX_W-1:0] pool_q;
	logic [IDX_W-1:0] head_q [NLISTS];
	logic [IDX_W-1:0] save_q [NLISTS];

	// working registers
	logic [31:0]      size_q;
	logic [CUR_W-1:0] want_q;
	logic [CUR_W-1:0] cur_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] b_q;
	logic [IDX_W-1:0] prev_q;
	logic [IDX_W-1:0] chn_q;
	logic [STEPS_W-1:0] steps_q;
	word_t            bword_q;
	logic [LOG_CW-1:0] log_cnt_q;
	logic [PG_W-1:0]  sweep_q;
	logic [IDX_W-1:0] off_q;
	logic [31:0]      blk_q;
	logic [3:0]       st_q;

	// memories
	logic              ram_we;
	logic [PG_W-1:0]   ram_waddr;
	logic [PG_W-1:0]   ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	word_t             rd;
	word_t             wr_w;
	logic              log_we;
	logic [LOG_AW-1:0] log_waddr;
	logic [LOG_AW-1:0] log_raddr;
	log_t              log_wr;
	logic [LOG_W-1:0]  log_rdata;
	log_t              log_rd;

	// decode
	logic [3:0]       dec_st;
	logic [31:0]      size_d;
	logic [31:0]      free_off;
	logic [63:0]      free_lim;
	logic [IDX_W-1:0] free_idx;
	logic [32:0]      add_end;
	logic [32:0]      add_as;
	logic [32:0]      add_ae;
	logic [32:0]      add_pages;
	logic [IDX_W-1:0] add_pool;

	// per-step values
	logic [LW-1:0]    hc;
	logic [IDX_W-1:0] head_cur;
	logic [CUR_W-1:0] cm1;
	logic [31:0]      bs32;
	logic [31:0]      bf32;
	logic [31:0]      gn32;
	logic             g_grow;
	logic             size_fit;

	assign rd     = word_t'(ram_rdata);
	assign log_rd = log_t'(log_rdata);

	assign block_address = blk_q;
	assign status        = st_q;

	assign hc       = LW'(cur_q);
	assign head_cur = (cur_q <= CUR_W'(TOP_ORDER)) ? head_q[hc] : NIL;
	assign cm1      = cur_q - CUR_W'(1);
	assign bs32     = 32'(idx_q) + (32'd1 << cm1);
	assign bf32     = 32'(idx_q) ^ (32'd1 << cur_q);
	assign gn32     = 32'd2 << cur_q;
	assign g_grow   = (cur_q < CUR_W'(TOP_ORDER)) && ((32'(off_q) & (gn32 - 32'd1)) == 32'd0)
		&& ((32'(off_q) + gn32) <= 32'(pool_q));
	assign size_fit = ((size_q - 32'd1) >> (PAGE_BITS + int'(cur_q))) == 32'd0;

	// request decode and early checks
	always_comb begin
		free_off  = adr_q - base_q;
		free_lim  = 64'(pool_q) << PAGE_BITS;
		free_idx  = IDX_W'(free_off >> PAGE_BITS);
		add_end   = {1'b0, adr_q} + {1'b0, req_q};
		add_as    = ({1'b0, adr_q} + PMASK) & ~PMASK;
		add_ae    = add_end & ~PMASK;
		add_pages = (add_ae - add_as) >> PAGE_BITS;
		add_pool  = (add_pages > 33'(MAX_PAGES)) ? IDX_W'(MAX_PAGES) : IDX_W'(add_pages);
		size_d    = req_q;
		dec_st    = ST_OK;
		unique case (kind_q)
			K_ORD: begin
				if (ordin_q > ORD_W'(TOP_ORDER)) dec_st = ST_BIG;
			end
			K_BYTES: begin
				if (req_q == 32'd0) dec_st = ST_NULL;
			end
			K_PAGES: begin
				size_d = req_q << PAGE_BITS;
				priority if (req_q == 32'd0)                  dec_st = ST_NULL;
				else if ((req_q >> (32 - PAGE_BITS)) != 32'd0) dec_st = ST_BIG;
				else                                          dec_st = ST_OK;
			end
			K_FREE: begin
				priority if (adr_q == 32'd0)                          dec_st = ST_NULL;
				else if ((adr_q & PMASK[31:0]) != 32'd0)               dec_st = ST_ALIGN;
				else if ((pool_q == '0) || (adr_q < base_q))           dec_st = ST_RANGE;
				else if (64'(free_off) >= free_lim)                    dec_st = ST_RANGE;
				else                                                  dec_st = ST_OK;
			end
			K_ADD: begin
				priority if ((req_q == 32'd0) || add_end[32]) dec_st = ST_WRAP;
				else if (add_ae <= add_as)                    dec_st = ST_SMALL;
				else                                          dec_st = ST_OK;
			end
			default: dec_st = ST_NULL;
		endcase
	end

	always_comb begin
		stat.dec_err    = (dec_st != ST_OK);
		stat.k_ord      = (kind_q == K_ORD);
		stat.k_size     = (kind_q == K_BYTES) || (kind_q == K_PAGES);
		stat.k_free     = (kind_q == K_FREE);
		stat.k_add      = (kind_q == K_ADD);
		stat.size_over  = (cur_q > CUR_W'(TOP_ORDER));
		stat.size_fit   = size_fit;
		stat.scan_over  = (cur_q > CUR_W'(TOP_ORDER));
		stat.scan_hit   = (head_cur != NIL);
		stat.split_more = (cur_q > want_q);
		stat.fchk_err   = rd.fr || (rd.ord > ORD_W'(TOP_ORDER))
			|| ((32'(idx_q) & ((32'd1 << rd.ord) - 32'd1)) != 32'd0);
		stat.floop_stop = (cur_q >= CUR_W'(TOP_ORDER)) || (bf32 >= 32'(pool_q))
			|| (bf32 >= 32'(MAX_PAGES));
		stat.fbud_stop  = !rd.fr || (rd.ord != ORD_W'(cur_q));
		stat.u_fail     = (chn_q >= NIL) || (steps_q > STEPS_W'(MAX_PAGES));
		stat.u_hit      = (chn_q == b_q);
		stat.u_prev_nil = (prev_q == NIL);
		stat.log_empty  = (log_cnt_q == '0);
		stat.sweep_last = (sweep_q == PG_W'(MAX_PAGES - 1));
		stat.g_end      = (off_q >= pool_q);
	end

	// memory ports
	always_comb begin
		ram_raddr = PG_W'(idx_q);
		ram_we    = 1'b0;
		ram_waddr = PG_W'(idx_q);
		wr_w      = rd;
		log_we    = 1'b0;
		log_waddr = LOG_AW'(log_cnt_q);
		log_raddr = LOG_AW'(log_cnt_q - LOG_CW'(1));
		log_wr.a  = PG_W'(idx_q);
		log_wr.w  = rd;
		unique case (cmd.step)
			S_DEC:   ram_raddr = PG_W'(free_idx);
			S_SCAN:  ram_raddr = PG_W'(head_cur);
			S_POP: begin
				ram_we   = 1'b1;
				wr_w.nxt = NIL;
				wr_w.ord = (cur_q > want_q) ? ORD_W'(want_q) : rd.ord;
				wr_w.fr  = 1'b0;
			end
			S_SPLIT: begin
				ram_we    = (cur_q > want_q) && (bs32 < 32'(MAX_PAGES));
				ram_waddr = PG_W'(bs32);
				wr_w.nxt  = head_q[LW'(cm1)];
				wr_w.ord  = ORD_W'(cm1);
				wr_w.fr   = 1'b1;
			end
			S_FRD: begin
				ram_we    = !stat.fchk_err;
				log_we    = !stat.fchk_err;
				log_waddr = '0;
				wr_w.fr   = 1'b1;
			end
			S_FLOOP: ram_raddr = PG_W'(bf32);
			S_UCHK:  ram_raddr = stat.u_hit ? PG_W'(prev_q) : PG_W'(chn_q);
			S_UPW: begin
				ram_we    = 1'b1;
				ram_waddr = PG_W'(prev_q);
				wr_w.nxt  = bword_q.nxt;
				log_we    = 1'b1;
				log_wr.a  = PG_W'(prev_q);
			end
			S_UBW: begin
				ram_we    = 1'b1;
				ram_waddr = PG_W'(b_q);
				wr_w.nxt  = NIL;
				wr_w.ord  = bword_q.ord;
				wr_w.fr   = 1'b0;
				log_we    = 1'b1;
				log_wr.a  = PG_W'(b_q);
				log_wr.w  = bword_q;
			end
			S_MWR: begin
				ram_we   = 1'b1;
				wr_w.ord = ORD_W'(cur_q);
				wr_w.fr  = 1'b1;
				log_we   = 1'b1;
			end
			S_PUSHW: begin
				ram_we   = 1'b1;
				wr_w.nxt = head_cur;
			end
			S_RWR: begin
				ram_we    = 1'b1;
				ram_waddr = log_rd.a;
				wr_w      = log_rd.w;
			end
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				wr_w.nxt  = NIL;
				wr_w.ord  = '0;
				wr_w.fr   = 1'b1;
			end
			S_GORD: begin
				ram_we    = !stat.g_end && !g_grow;
				ram_waddr = PG_W'(off_q);
				wr_w.nxt  = head_cur;
				wr_w.ord  = ORD_W'(cur_q);
				wr_w.fr   = 1'b1;
			end
			default: ram_raddr = PG_W'(idx_q);
		endcase
		ram_wdata = wr_w;
	end

	bpa_ram #(.W(WORD_W), .D(MAX_PAGES)) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bpa_ram #(.W(LOG_W), .D(LOG_DEPTH)) u_log_ram (
		.clk   (clk),
		.we    (log_we),
		.waddr (log_waddr),
		.wdata (log_wr),
		.raddr (log_raddr),
		.rdata (log_rdata)
	);

	// region and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			pool_q <= '0;
			for (int i = 0; i < NLISTS; i++) head_q[i] <= NIL;
		end else begin
			unique case (cmd.step)
				S_DEC: begin
					if (kind_q == K_ADD && dec_st == ST_OK) begin
						base_q <= add_as[31:0];
						pool_q <= add_pool;
						for (int i = 0; i < NLISTS; i++) head_q[i] <= NIL;
					end
				end
				S_POP:   head_q[hc] <= rd.nxt;
				S_SPLIT: begin
					if ((cur_q > want_q) && (bs32 < 32'(MAX_PAGES))) begin
						head_q[LW'(cm1)] <= IDX_W'(bs32);
					end
				end
				S_UCHK: begin
					if (!stat.u_fail && stat.u_hit && stat.u_prev_nil) head_q[hc] <= bword_q.nxt;
				end
				S_PUSHW: head_q[hc] <= idx_q;
				S_RST: begin
					for (int i = 0; i < NLISTS; i++) head_q[i] <= save_q[i];
				end
				S_GORD: begin
					if (!stat.g_end && !g_grow) head_q[hc] <= off_q;
				end
				default: base_q <= base_q;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			ordin_q <= order;
			req_q   <= request_size;
			adr_q   <= address;
		end
		unique case (cmd.step)
			S_DEC: begin
				st_q    <= dec_st;
				blk_q   <= '0;
				size_q  <= size_d;
				want_q  <= CUR_W'(ordin_q);
				cur_q   <= (kind_q == K_ORD) ? CUR_W'(ordin_q) : '0;
				idx_q   <= free_idx;
				sweep_q <= '0;
				off_q   <= '0;
			end
			S_SIZE: begin
				if (cur_q > CUR_W'(TOP_ORDER)) st_q <= ST_BIG;
				else if (size_fit) want_q <= cur_q;
				else cur_q <= cur_q + CUR_W'(1);
			end
			S_SCAN: begin
				if (cur_q > CUR_W'(TOP_ORDER)) st_q <= ST_EMPTY;
				else if (head_cur != NIL) idx_q <= head_cur;
				else cur_q <= cur_q + CUR_W'(1);
			end
			S_SPLIT: begin
				if (cur_q > want_q) cur_q <= cm1;
				else blk_q <= base_q + (32'(idx_q) << PAGE_BITS);
			end
			S_FRD: begin
				if (rd.fr) st_q <= ST_DFREE;
				else if (stat.fchk_err) st_q <= ST_BLK;
				cur_q     <= CUR_W'(rd.ord);
				log_cnt_q <= LOG_CW'(1);
				for (int i = 0; i < NLISTS; i++) save_q[i] <= head_q[i];
			end
			S_FLOOP: b_q <= IDX_W'(bf32);
			S_FBUD: begin
				bword_q <= rd;
				prev_q  <= NIL;
				chn_q   <= head_cur;
				steps_q <= '0;
			end
			S_UNXT: begin
				prev_q  <= chn_q;
				chn_q   <= rd.nxt;
				steps_q <= steps_q + STEPS_W'(1);
			end
			S_UPW: log_cnt_q <= log_cnt_q + LOG_CW'(1);
			S_UBW: begin
				log_cnt_q <= log_cnt_q + LOG_CW'(1);
				if (b_q < idx_q) idx_q <= b_q;
				cur_q <= cur_q + CUR_W'(1);
			end
			S_MWR:   log_cnt_q <= log_cnt_q + LOG_CW'(1);
			S_PUSHW: st_q <= ST_OK;
			S_RST:   st_q <= ST_DFREE;
			S_RRD:   log_cnt_q <= log_cnt_q - LOG_CW'(1);
			S_SWEEP: sweep_q <= sweep_q + PG_W'(1);
			S_GORD: begin
				if (!stat.g_end) begin
					if (g_grow) begin
						cur_q <= cur_q + CUR_W'(1);
					end else begin
						off_q <= off_q + IDX_W'(32'd1 << cur_q);
						cur_q <= '0;
					end
				end
			end
			default: st_q <= st_q;
		endcase
	end
endmodule

### rtl/buddy_page_allocator.sv
// Buddy page allocator over one region of 4 KiB pages, up to 1024 pages and
// blocks of order 0 to 10. Raise start for one cycle while busy is low with
// kind and its operands; the block takes the beat and raises busy. Exactly
// one result beat follows: done is high for a single cycle with
// block_address and status, and the receiver must take it then, as there is
// no way to hold it off. busy falls in the cycle after done is shown. An
// allocation by order scans the lists upward from the wanted order and
// then splits the block found down to it; allocation by size first tests
// orders upward for the smallest that fits; a free merges buddies one
// order at a time, walking a list to unlink each buddy, and a free that
// meets a broken list restores the list heads and undoes its record writes
// from the undo log; adding a region first sweeps all 1024 page records and
// then seeds blocks, trying orders upward for each. Errors leave the state
// unchanged.
module buddy_page_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [2:0]  kind,
	input  logic [3:0]  order,
	input  logic [31:0] request_size,
	input  logic [31:0] address,
	output logic [31:0] block_address,
	output logic [3:0]  status
);
	import bpa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequence each request: decode, walk the lists, then hand out the beat
	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// hold the region, list heads, page records and the undo log
	bpa_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.kind          (kind),
		.order         (order),
		.request_size  (request_size),
		.address       (address),
		.block_address (block_address),
		.status        (status)
	);
endmodule

### rtl/bpa_chk.sv
module bpa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] block_address,
	input logic [3:0]  status
);
	import bpa_pkg::*;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accepted beat not taken up");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (block_address == 32'd0))
		else $error("failed request carries an address");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_WRAP)) else $error("status code out of range");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done)) else $error("busy dropped without a result");
endmodule

bind buddy_page_allocator bpa_chk u_bpa_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.block_address (block_address),
	.status        (status)
);
